FILE: rtl/core/pts_pkg.sv
// Package for the personal-data token scanner.
// Holds the request and result types, the byte class type and the counter limits.
// Depends on nothing.
package pts_pkg;

  localparam int TEXT_COUNT_BITS  = 16;
  localparam int TOTAL_COUNT_BITS = 32;
  localparam int QUEUE_DEPTH      = 4;

  localparam logic [3:0] LEN_CAP        = 4'd12;
  localparam logic [3:0] SHAPE_LEN      = 4'd11;
  localparam logic [3:0] SHAPE_DASH_A   = 4'd3;
  localparam logic [3:0] SHAPE_DASH_B   = 4'd6;
  localparam logic [4:0] DIGIT_CAP      = 5'd20;
  localparam logic [4:0] NUM_MIN_DIGITS = 5'd10;
  localparam logic [4:0] NUM_MAX_DIGITS = 5'd19;

  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_HYPHEN = 8'h2D;
  localparam logic [7:0] CHAR_AT     = 8'h40;
  localparam logic [7:0] CHAR_DOT    = 8'h2E;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [TEXT_COUNT_BITS-1:0]  text_match_count;
    logic [TOTAL_COUNT_BITS-1:0] total_exposure_count;
  } out_item_t;

  typedef struct packed {
    logic space;
    logic digit;
    logic hyphen;
    logic at_sign;
    logic dot;
    logic end_of_text;
  } byte_class_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

FILE: rtl/core/pts_front.sv
// Front stage of the token scanner: accepts byte requests and classifies them.
// Feeds the request queue. Depends on pts_pkg.
module pts_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pts_pkg::in_item_t   in_data,
  input  pts_pkg::queue_stat_t q_stat,
  output logic                push,
  output pts_pkg::byte_class_t push_class
);
  import pts_pkg::*;

  logic        valid_r, valid_nxt;
  byte_class_t class_r, class_nxt;
  byte_class_t cls;
  logic        accept;

  always_comb begin
    cls.space       = (in_data.text_byte == CHAR_SPACE) ||
                      ((in_data.text_byte >= CHAR_TAB) && (in_data.text_byte <= CHAR_CR));
    cls.digit       = (in_data.text_byte >= CHAR_ZERO) && (in_data.text_byte <= CHAR_NINE);
    cls.hyphen      = in_data.text_byte == CHAR_HYPHEN;
    cls.at_sign     = in_data.text_byte == CHAR_AT;
    cls.dot         = in_data.text_byte == CHAR_DOT;
    cls.end_of_text = in_data.end_of_text;
  end

  assign in_stall   = valid_r && q_stat.full;
  assign accept     = in_valid && !in_stall;
  assign push       = valid_r && !q_stat.full;
  assign push_class = class_r;

  always_comb begin
    valid_nxt = valid_r;
    class_nxt = class_r;
    if (accept) begin
      valid_nxt = 1'b1;
      class_nxt = cls;
    end else if (push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    class_r <= class_nxt;
  end

endmodule

FILE: rtl/core/pts_queue.sv
// Short queue of classified byte requests between the front and back stages.
// Depends on pts_pkg.
module pts_queue #(
  parameter int DEPTH = pts_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  pts_pkg::byte_class_t push_class,
  input  logic                 pop,
  output pts_pkg::byte_class_t head_class,
  output pts_pkg::queue_stat_t q_stat
);
  import pts_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  byte_class_t            slot_r [DEPTH];
  logic [PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;

  assign q_stat.full  = count_r == CNT_W'(DEPTH);
  assign q_stat.empty = count_r == '0;
  assign head_class   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_class;
    end
  end

endmodule

FILE: rtl/core/pts_back.sv
// Back stage of the token scanner: tracks the open token, classifies closed tokens,
// keeps the saturating counts and holds the result register. Depends on pts_pkg.
module pts_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pts_pkg::byte_class_t head_class,
  input  pts_pkg::queue_stat_t q_stat,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pts_pkg::out_item_t   out_data
);
  import pts_pkg::*;

  logic                        inside_r, inside_nxt;
  logic [3:0]                  len_r, len_nxt;
  logic [4:0]                  digits_r, digits_nxt;
  logic                        hyphen_r, hyphen_nxt;
  logic                        at_r, at_nxt;
  logic                        dot_r, dot_nxt;
  logic                        shape_r, shape_nxt;
  logic [TEXT_COUNT_BITS-1:0]  text_r, text_nxt;
  logic [TOTAL_COUNT_BITS-1:0] grand_r, grand_nxt;
  logic                        out_valid_r, out_valid_nxt;
  out_item_t                   out_data_r, out_data_nxt;

  logic [3:0]                  upd_len;
  logic [4:0]                  upd_digits;
  logic                        upd_shape;
  logic                        want_hyphen;
  logic                        c_inside;
  logic [3:0]                  c_len;
  logic [4:0]                  c_digits;
  logic                        c_hyphen;
  logic                        c_dot;
  logic                        c_shape;
  logic                        numeric;
  logic                        shaped;
  logic                        hit;
  logic                        closing;
  logic [TEXT_COUNT_BITS-1:0]  text_sum;
  logic [TOTAL_COUNT_BITS-1:0] grand_sum;

  assign pop = !q_stat.empty && (!head_class.end_of_text || !out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    upd_len     = (len_r < LEN_CAP) ? len_r + 4'd1 : LEN_CAP;
    upd_digits  = (head_class.digit && (digits_r < DIGIT_CAP)) ? digits_r + 5'd1 : digits_r;
    want_hyphen = (len_r == SHAPE_DASH_A) || (len_r == SHAPE_DASH_B);
    upd_shape   = shape_r;
    if (len_r < SHAPE_LEN) begin
      if (want_hyphen ? !head_class.hyphen : !head_class.digit) begin
        upd_shape = 1'b0;
      end
    end

    if (head_class.space) begin
      c_inside = inside_r;
      c_len    = len_r;
      c_digits = digits_r;
      c_hyphen = hyphen_r;
      c_dot    = dot_r;
      c_shape  = shape_r;
    end else begin
      c_inside = 1'b1;
      c_len    = upd_len;
      c_digits = upd_digits;
      c_hyphen = hyphen_r || head_class.hyphen;
      c_dot    = dot_r || (head_class.dot && at_r);
      c_shape  = upd_shape;
    end

    numeric = c_hyphen && (c_digits >= NUM_MIN_DIGITS) && (c_digits <= NUM_MAX_DIGITS);
    shaped  = (c_len == SHAPE_LEN) && c_shape;
    closing = head_class.space || head_class.end_of_text;
    hit     = closing && c_inside && (c_dot || numeric || shaped);

    text_sum  = (hit && (text_r != '1)) ?
                text_r + {{(TEXT_COUNT_BITS-1){1'b0}}, 1'b1} : text_r;
    grand_sum = (hit && (grand_r != '1)) ?
                grand_r + {{(TOTAL_COUNT_BITS-1){1'b0}}, 1'b1} : grand_r;

    inside_nxt    = inside_r;
    len_nxt       = len_r;
    digits_nxt    = digits_r;
    hyphen_nxt    = hyphen_r;
    at_nxt        = at_r;
    dot_nxt       = dot_r;
    shape_nxt     = shape_r;
    text_nxt      = text_r;
    grand_nxt     = grand_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (pop) begin
      if (closing) begin
        inside_nxt = 1'b0;
        len_nxt    = '0;
        digits_nxt = '0;
        hyphen_nxt = 1'b0;
        at_nxt     = 1'b0;
        dot_nxt    = 1'b0;
        shape_nxt  = 1'b1;
      end else begin
        inside_nxt = 1'b1;
        len_nxt    = upd_len;
        digits_nxt = upd_digits;
        hyphen_nxt = c_hyphen;
        at_nxt     = at_r || head_class.at_sign;
        dot_nxt    = c_dot;
        shape_nxt  = upd_shape;
      end
      grand_nxt = grand_sum;
      if (head_class.end_of_text) begin
        text_nxt                          = '0;
        out_valid_nxt                     = 1'b1;
        out_data_nxt.text_match_count     = text_sum;
        out_data_nxt.total_exposure_count = grand_sum;
      end else begin
        text_nxt = text_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r    <= 1'b0;
      len_r       <= '0;
      digits_r    <= '0;
      hyphen_r    <= 1'b0;
      at_r        <= 1'b0;
      dot_r       <= 1'b0;
      shape_r     <= 1'b1;
      text_r      <= '0;
      grand_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      inside_r    <= inside_nxt;
      len_r       <= len_nxt;
      digits_r    <= digits_nxt;
      hyphen_r    <= hyphen_nxt;
      at_r        <= at_nxt;
      dot_r       <= dot_nxt;
      shape_r     <= shape_nxt;
      text_r      <= text_nxt;
      grand_r     <= grand_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  a_len_cap : assert property (@(posedge clk) disable iff (!rst_n) len_r <= LEN_CAP)
    else $error("token length above its cap");

  a_digit_cap : assert property (@(posedge clk) disable iff (!rst_n) digits_r <= DIGIT_CAP)
    else $error("digit tally above its cap");

  a_idle_token : assert property (@(posedge clk) disable iff (!rst_n)
    !inside_r |-> (len_r == '0) && shape_r && !at_r && !dot_r)
    else $error("closed token left state behind");

  a_grand_monotonic : assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> grand_r >= $past(grand_r))
    else $error("running total decreased");

  a_result_hold : assert property (@(posedge clk) disable iff (!rst_n)
    $past(out_valid_r) && $past(out_stall) |-> out_valid_r && $stable(out_data_r))
    else $error("stalled result was dropped or changed");

endmodule

FILE: rtl/core/pii_token_scanner.sv
// Top level of the personal-data token scanner.
// Instantiates pts_front, pts_queue and pts_back. Depends on pts_pkg.
//
// The scanner takes one text byte per clock cycle while in_stall is low and,
// on the request that carries end_of_text, returns one result with the number
// of personal-data tokens in that text and the running total since reset;
// other requests give no result. Bytes are classified in a front register,
// pass through a queue of QUEUE_DEPTH entries and are folded into the open
// token by the back stage, which updates its flags and saturating counters
// for each byte, so the sustained rate is one byte per cycle while nothing
// stalls. With no stall, out_valid rises from the result register once the
// final byte has passed the front register and the queue. A stalled result
// holds the next end_of_text request at the head of the queue and the bytes
// behind it wait; once queue and front register are full, in_stall rises.
module pii_token_scanner #(
  parameter int QUEUE_DEPTH = pts_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pts_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pts_pkg::out_item_t out_data
);
  import pts_pkg::*;

  queue_stat_t q_stat;
  byte_class_t push_class;
  byte_class_t head_class;
  logic        push;
  logic        pop;

  pts_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .q_stat     (q_stat),
    .push       (push),
    .push_class (push_class)
  );

  pts_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_class (push_class),
    .pop        (pop),
    .head_class (head_class),
    .q_stat     (q_stat)
  );

  pts_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_class (head_class),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
